// ----- sv/alq_pkg.sv -----
// Shared types and constants for the adaptive level quantizer.
// No dependencies; imported by alq_ctrl, alq_datapath and the top level.
package alq_pkg;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int TIME_W    = 32;
    localparam int TRACK_W   = 16;
    localparam int LEVEL_W   = 2;
    localparam int LCOUNT_W  = 3;
    localparam int REFR_W    = 16;
    localparam int HCOUNT_W  = 8;
    localparam int QUOT_W    = 3;
    localparam int DIV_W     = 18;
    localparam int SHIFT_W   = 2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Stream packing
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REFRACTORY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REST_LEVEL  = 2'd2;

    // Reset values and tuning constants
    localparam logic [LCOUNT_W-1:0]       LEVEL_COUNT_RESET = 3'd3;
    localparam logic signed [TRACK_W-1:0] MIN_RESET         = 16'sd10000;
    localparam logic signed [TRACK_W-1:0] MAX_RESET         = -16'sd10000;
    localparam logic signed [TRACK_W-1:0] MIN_SPREAD        = 16'sd100;
    localparam logic signed [TRACK_W-1:0] SPREAD_PUSH       = 16'sd50;
    localparam logic [HCOUNT_W-1:0]       HOLD_REPEATS      = 8'd6;
    localparam logic [HCOUNT_W-1:0]       HOLD_COUNT_MAX    = 8'hFF;
    localparam logic [TIME_W-1:0]         HOLD_TIME_MS      = 32'd10000;
    localparam logic [SHIFT_W-1:0]        DIV_FIRST_SHIFT   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic               load;
        logic               range_upd;
        logic               spread;
        logic               prep;
        logic               mult;
        logic               div_step;
        logic [SHIFT_W-1:0] div_shift;
        logic               commit;
    } alq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } alq_status_t;

endpackage

// ----- sv/alq_ctrl.sv -----
// Sequencing controller for the adaptive level quantizer.
// Depends on alq_pkg; drives the command struct of alq_datapath.
module alq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  alq_pkg::alq_status_t status,
    output alq_pkg::alq_cmd_t   cmd
);
    import alq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_SPREAD,
        ST_PREP,
        ST_MULT,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        cmd            = '0;
        cmd.div_shift  = shift_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                cmd.range_upd = 1'b1;
                state_next    = ST_SPREAD;
            end
            ST_SPREAD:
            begin
                cmd.spread = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult   = 1'b1;
                shift_next = DIV_FIRST_SHIFT;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (shift_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    shift_next = shift_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            shift_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// ----- sv/alq_datapath.sv -----
// Datapath of the adaptive level quantizer: range tracking, level mapping
// by a 3-step restoring divide, hold logic, config and result registers.
// Depends on alq_pkg; sequenced by alq_ctrl through alq_cmd_t.
module alq_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  alq_pkg::alq_cmd_t                   cmd,
    output alq_pkg::alq_status_t                status,
    input  logic [alq_pkg::SAMPLE_W-1:0]        in_sample,
    input  logic [alq_pkg::TIME_W-1:0]          in_now_ms,
    input  logic                                cfg_we,
    input  logic [alq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [alq_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [alq_pkg::LEVEL_W-1:0]         out_level,
    output logic                                out_in_refractory,
    output logic                                out_recalibrated,
    output logic signed [alq_pkg::TRACK_W-1:0]  out_range_low,
    output logic signed [alq_pkg::TRACK_W-1:0]  out_range_high
);
    import alq_pkg::*;

    // Configuration
    logic [LCOUNT_W-1:0] lc_reg, lc_next;
    logic [REFR_W-1:0]   refr_ms_reg, refr_ms_next;
    logic [LEVEL_W-1:0]  rest_reg, rest_next;

    // Tracked state
    logic signed [TRACK_W-1:0] tmin_reg, tmin_next;
    logic signed [TRACK_W-1:0] tmax_reg, tmax_next;
    logic [HCOUNT_W-1:0]       hc_reg, hc_next;
    logic [LEVEL_W-1:0]        held_reg, held_next;
    logic [TIME_W-1:0]         hold_start_reg, hold_start_next;
    logic [TIME_W-1:0]         last_change_reg, last_change_next;

    // Per-item working registers
    logic [SAMPLE_W-1:0]       sample_reg, sample_next;
    logic [TIME_W-1:0]         now_reg, now_next;
    logic                      refr_reg, refr_next;
    logic                      elapsed_reg, elapsed_next;
    logic signed [TRACK_W-1:0] span_reg, span_next;
    logic signed [TRACK_W-1:0] off_reg, off_next;
    logic                      span_ok_reg, span_ok_next;
    logic [DIV_W-1:0]          rem_reg, rem_next;
    logic [QUOT_W-1:0]         q_reg, q_next;

    // Result register
    logic                      out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0]        out_level_reg, out_level_next;
    logic                      out_refr_reg, out_refr_next;
    logic                      out_recal_reg, out_recal_next;
    logic signed [TRACK_W-1:0] out_low_reg, out_low_next;
    logic signed [TRACK_W-1:0] out_high_reg, out_high_next;

    // Helpers
    logic signed [TRACK_W-1:0] sample_s;
    logic signed [TRACK_W-1:0] spread;
    logic signed [TRACK_W-1:0] spread_abs;
    logic [LCOUNT_W-1:0]       lc_eff;
    logic [DIV_W-1:0]          trial;
    logic [QUOT_W-1:0]         x_raw;
    logic [QUOT_W-1:0]         x_clamp;
    logic [LEVEL_W-1:0]        lvl;
    logic [HCOUNT_W-1:0]       hc_sat;

    assign sample_s   = $signed({{(TRACK_W-SAMPLE_W){1'b0}}, sample_reg});
    assign spread     = tmax_reg - tmin_reg;
    assign spread_abs = spread[TRACK_W-1] ? -spread : spread;
    assign trial      = DIV_W'(span_reg[TRACK_W-2:0]) << cmd.div_shift;
    assign hc_sat     = (hc_reg == HOLD_COUNT_MAX) ? hc_reg : hc_reg + 1'b1;

    // Level count clamped to 1..4
    always_comb
    begin
        case (lc_reg)
            3'd0:                   lc_eff = 3'd1;
            3'd1, 3'd2, 3'd3, 3'd4: lc_eff = lc_reg;
            default:                lc_eff = 3'd4;
        endcase
    end

    // Quotient clamped to the top level
    assign x_raw   = span_ok_reg ? q_reg : '0;
    assign x_clamp = (x_raw > lc_eff - 1'b1) ? lc_eff - 1'b1 : x_raw;
    assign lvl     = refr_reg ? held_reg : x_clamp[LEVEL_W-1:0];

    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        lc_next          = lc_reg;
        refr_ms_next     = refr_ms_reg;
        rest_next        = rest_reg;
        tmin_next        = tmin_reg;
        tmax_next        = tmax_reg;
        hc_next          = hc_reg;
        held_next        = held_reg;
        hold_start_next  = hold_start_reg;
        last_change_next = last_change_reg;
        sample_next      = sample_reg;
        now_next         = now_reg;
        refr_next        = refr_reg;
        elapsed_next     = elapsed_reg;
        span_next        = span_reg;
        off_next         = off_reg;
        span_ok_next     = span_ok_reg;
        rem_next         = rem_reg;
        q_next           = q_reg;
        out_valid_next   = out_ready ? 1'b0 : out_valid_reg;
        out_level_next   = out_level_reg;
        out_refr_next    = out_refr_reg;
        out_recal_next   = out_recal_reg;
        out_low_next     = out_low_reg;
        out_high_next    = out_high_reg;

        // Register writes, issued only while idle: a rule for the user, not enforced here
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEVEL_COUNT: lc_next = cfg_data[LCOUNT_W-1:0];
                REG_REFRACTORY:  refr_ms_next = cfg_data[REFR_W-1:0];
                REG_REST_LEVEL:
                begin
                    rest_next = cfg_data[LEVEL_W-1:0];
                    held_next = cfg_data[LEVEL_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        // Capture the item
        if (cmd.load)
        begin
            sample_next = in_sample;
            now_next    = in_now_ms;
        end

        // Widen the range to the sample
        if (cmd.range_upd)
        begin
            if (sample_s < tmin_reg)
            begin
                tmin_next = sample_s;
            end
            if (sample_s > tmax_reg)
            begin
                tmax_next = sample_s;
            end
        end

        // Push a narrow range outward
        if (cmd.spread && (spread_abs < MIN_SPREAD))
        begin
            if (rest_reg == '0)
            begin
                tmin_next = tmin_reg - SPREAD_PUSH;
            end
            else
            begin
                tmax_next = tmax_reg + SPREAD_PUSH;
            end
        end

        // Window checks and mapping operands
        if (cmd.prep)
        begin
            refr_next    = (now_reg - last_change_reg) < {{(TIME_W-REFR_W){1'b0}}, refr_ms_reg};
            elapsed_next = (now_reg - hold_start_reg) > HOLD_TIME_MS;
            span_next    = tmax_reg - tmin_reg;
            off_next     = sample_s - tmin_reg;
        end

        // Numerator (sample - min) * levels
        if (cmd.mult)
        begin
            span_ok_next = !span_reg[TRACK_W-1] && (span_reg != '0) &&
                           !off_reg[TRACK_W-1] && (off_reg != '0);
            rem_next     = span_ok_next ?
                           DIV_W'(off_reg[TRACK_W-2:0]) * DIV_W'(lc_eff) : '0;
            q_next       = '0;
        end

        // One restoring divide step
        if (cmd.div_step && (rem_reg >= trial))
        begin
            rem_next                = rem_reg - trial;
            q_next[cmd.div_shift]   = 1'b1;
        end

        // Hold bookkeeping and result
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            out_level_next = lvl;
            out_refr_next  = refr_reg;
            out_recal_next = 1'b0;
            if (!refr_reg && (lvl != rest_reg))
            begin
                if (lvl == held_reg)
                begin
                    hc_next = hc_sat;
                    if ((hc_sat > HOLD_REPEATS) && elapsed_reg)
                    begin
                        tmin_next        = MIN_RESET;
                        tmax_next        = MAX_RESET;
                        hc_next          = '0;
                        held_next        = rest_reg;
                        hold_start_next  = now_reg;
                        last_change_next = now_reg;
                        out_recal_next   = 1'b1;
                    end
                end
                else
                begin
                    held_next        = lvl;
                    hc_next          = '0;
                    hold_start_next  = now_reg;
                    last_change_next = now_reg;
                end
            end
            out_low_next  = tmin_next;
            out_high_next = tmax_next;
        end
    end

    // Control and tracked state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lc_reg          <= LEVEL_COUNT_RESET;
            refr_ms_reg     <= '0;
            rest_reg        <= '0;
            tmin_reg        <= MIN_RESET;
            tmax_reg        <= MAX_RESET;
            hc_reg          <= '0;
            held_reg        <= '0;
            hold_start_reg  <= '0;
            last_change_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            lc_reg          <= lc_next;
            refr_ms_reg     <= refr_ms_next;
            rest_reg        <= rest_next;
            tmin_reg        <= tmin_next;
            tmax_reg        <= tmax_next;
            hc_reg          <= hc_next;
            held_reg        <= held_next;
            hold_start_reg  <= hold_start_next;
            last_change_reg <= last_change_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        now_reg       <= now_next;
        refr_reg      <= refr_next;
        elapsed_reg   <= elapsed_next;
        span_reg      <= span_next;
        off_reg       <= off_next;
        span_ok_reg   <= span_ok_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        out_level_reg <= out_level_next;
        out_refr_reg  <= out_refr_next;
        out_recal_reg <= out_recal_next;
        out_low_reg   <= out_low_next;
        out_high_reg  <= out_high_next;
    end

    assign out_valid         = out_valid_reg;
    assign out_level         = out_level_reg;
    assign out_in_refractory = out_refr_reg;
    assign out_recalibrated  = out_recal_reg;
    assign out_range_low     = out_low_reg;
    assign out_range_high    = out_high_reg;

`ifndef SYNTHESIS
    // A mapped level never exceeds the top level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_refr_reg |->
            ({1'b0, out_level_reg} <= lc_eff - 1'b1))
        else $error("mapped level above top level");

    // Recalibration only on mapped items and returns the range to reset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_recal_reg |->
            !out_refr_reg && (out_low_reg == MIN_RESET) && (out_high_reg == MAX_RESET))
        else $error("recalibration result inconsistent");

    // A refractory result carries the held level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_refr_reg |-> (out_level_reg == held_reg))
        else $error("refractory level differs from held level");
`endif

endmodule

// ----- sv/adaptive_level_quantizer.sv -----
// Top level of the adaptive level quantizer: stream ports, config port,
// controller and datapath. Depends on alq_pkg, alq_ctrl, alq_datapath.
//
// Each input item (sample, millisecond timestamp) widens a tracked min/max
// range, then yields one result item: the held level inside the refractory
// window, else the sample mapped onto 1..4 levels over the range. An item
// passes through the sequencer from acceptance to its result register:
// range update, spread push, window check, multiply, three
// restoring divide steps and the commit; the commit waits while the
// previous result is still unclaimed. The next item is accepted only once
// the sequencer is back in idle after the commit, so no new item is taken
// while one is in flight. Register writes are taken at any cycle and
// must only be issued while no item is in flight.
module adaptive_level_quantizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [alq_pkg::IN_DATA_W-1:0]       s_tdata,   // sample[9:0], now_ms[41:10]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [alq_pkg::OUT_DATA_W-1:0]      m_tdata,   // level[1:0], in_refractory[2],
                                                           // recalibrated[3],
                                                           // range_low[19:4],
                                                           // range_high[35:20]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [alq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [alq_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import alq_pkg::*;

    alq_cmd_t    cmd;
    alq_status_t status;

    logic [LEVEL_W-1:0]        level;
    logic                      in_refractory;
    logic                      recalibrated;
    logic signed [TRACK_W-1:0] range_low;
    logic signed [TRACK_W-1:0] range_high;

    assign cfg_ready = 1'b1;

    alq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    alq_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_sample         (s_tdata[SAMPLE_W-1:0]),
        .in_now_ms         (s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W]),
        .cfg_we            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_level         (level),
        .out_in_refractory (in_refractory),
        .out_recalibrated  (recalibrated),
        .out_range_low     (range_low),
        .out_range_high    (range_high)
    );

    // Pack result fields, lowest first
    assign m_tdata = {4'b0, range_high, range_low, recalibrated, in_refractory, level};

`ifndef SYNTHESIS
    // A committed item shows up as a valid result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.commit) |-> m_tvalid)
        else $error("committed item not presented");
`endif

endmodule
